// ===== hw/rtl/suid_pkg.sv =====
package suid_pkg;

    // list tag carried by opcode
    localparam logic OP_LIST_A = 1'b0;
    localparam logic OP_LIST_B = 1'b1;

    // one flag per store: a values, union, intersection
    typedef struct packed {
        logic a;
        logic u;
        logic n;
    } store_flags_t;

endpackage

// ===== hw/rtl/suid_cell.sv =====
module suid_cell #(
    parameter int INDEX   = 0,
    parameter int VALUE_W = 16,
    parameter int CNT_W   = 7,
    parameter int IDX_W   = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    input  logic [VALUE_W-1:0]   in_value,
    input  suid_pkg::store_flags_t in_hit,
    input  logic [CNT_W-1:0]     cnt_a,
    input  logic [CNT_W-1:0]     cnt_u,
    input  logic [CNT_W-1:0]     cnt_n,
    input  suid_pkg::store_flags_t wr_en,
    input  logic [IDX_W-1:0]     wr_idx_a,
    input  logic [IDX_W-1:0]     wr_idx_u,
    input  logic [IDX_W-1:0]     wr_idx_n,
    input  logic [VALUE_W-1:0]   wr_value,
    output logic                 out_valid,
    output logic                 out_op,
    output logic [VALUE_W-1:0]   out_value,
    output suid_pkg::store_flags_t out_hit
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_W-1:0] a_val_reg;
    logic [VALUE_W-1:0] u_val_reg;
    logic [VALUE_W-1:0] n_val_reg;

    logic                   valid_reg;
    logic                   op_reg;
    logic [VALUE_W-1:0]     value_reg;
    suid_pkg::store_flags_t hit_reg;
    suid_pkg::store_flags_t hit_next;

    // a slot only counts once its store has filled past it
    always_comb
    begin
        hit_next.a = in_hit.a | ((MY_CNT < cnt_a) && (a_val_reg == in_value));
        hit_next.u = in_hit.u | ((MY_CNT < cnt_u) && (u_val_reg == in_value));
        hit_next.n = in_hit.n | ((MY_CNT < cnt_n) && (n_val_reg == in_value));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= in_op;
        value_reg <= in_value;
        hit_reg   <= hit_next;
        if (wr_en.a && (wr_idx_a == MY_IDX))
        begin
            a_val_reg <= wr_value;
        end
        if (wr_en.u && (wr_idx_u == MY_IDX))
        begin
            u_val_reg <= wr_value;
        end
        if (wr_en.n && (wr_idx_n == MY_IDX))
        begin
            n_val_reg <= wr_value;
        end
    end

    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_value = value_reg;
    assign out_hit   = hit_reg;

endmodule

// ===== hw/rtl/set_union_intersection_dedup_top.sv =====
// Keeps the distinct values of list A, the union and the intersection, each in
// first-arrival order. A request is taken when start is high and busy is low;
// it then walks the row of MAX_ELEMS compare cells one cell per cycle, and the
// result strobe (result_valid) is registered behind the last cell; busy drops
// with it, so a new request is only taken once the last result is out. The result
// is shown for one cycle only and cannot be held off by the receiver.
module set_union_intersection_dedup_top #(
    parameter int MAX_ELEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] item_value,
    output logic        result_valid,
    output logic [15:0] echo_value,
    output logic        union_added,
    output logic        inter_added,
    output logic [6:0]  union_count,
    output logic [6:0]  inter_count,
    output logic        overflow
);

    localparam int VALUE_W = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int CNT_W   = $clog2(MAX_ELEMS + 1);
    localparam int IDX_W   = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ELEMS);

    logic                   busy_reg;
    logic [CNT_W-1:0]       a_cnt_reg;
    logic [CNT_W-1:0]       u_cnt_reg;
    logic [CNT_W-1:0]       n_cnt_reg;
    logic                   res_valid_reg;
    logic [VALUE_W-1:0]     res_value_reg;
    logic                   res_u_add_reg;
    logic                   res_n_add_reg;
    logic                   res_ovf_reg;

    logic                   chain_valid [0:MAX_ELEMS];
    logic                   chain_op    [0:MAX_ELEMS];
    logic [VALUE_W-1:0]     chain_value [0:MAX_ELEMS];
    suid_pkg::store_flags_t chain_hit   [0:MAX_ELEMS];

    logic                   accept;
    logic                   tail_valid;
    logic                   tail_op;
    logic [VALUE_W-1:0]     tail_value;
    suid_pkg::store_flags_t tail_hit;
    suid_pkg::store_flags_t need;
    suid_pkg::store_flags_t full;
    suid_pkg::store_flags_t wr_en;
    logic                   ovf;

    logic [VALUE_W+15:0]    echo_ext;
    logic [CNT_W+6:0]       u_cnt_ext;
    logic [CNT_W+6:0]       n_cnt_ext;

    assign accept = start && !busy_reg;

    assign chain_valid[0] = accept;
    assign chain_op[0]    = opcode;
    assign chain_value[0] = item_value[VALUE_W-1:0];
    assign chain_hit[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMS; gi++)
        begin : g_cell
            suid_cell #(
                .INDEX   (gi),
                .VALUE_W (VALUE_W),
                .CNT_W   (CNT_W),
                .IDX_W   (IDX_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[gi]),
                .in_op     (chain_op[gi]),
                .in_value  (chain_value[gi]),
                .in_hit    (chain_hit[gi]),
                .cnt_a     (a_cnt_reg),
                .cnt_u     (u_cnt_reg),
                .cnt_n     (n_cnt_reg),
                .wr_en     (wr_en),
                .wr_idx_a  (a_cnt_reg[IDX_W-1:0]),
                .wr_idx_u  (u_cnt_reg[IDX_W-1:0]),
                .wr_idx_n  (n_cnt_reg[IDX_W-1:0]),
                .wr_value  (tail_value),
                .out_valid (chain_valid[gi+1]),
                .out_op    (chain_op[gi+1]),
                .out_value (chain_value[gi+1]),
                .out_hit   (chain_hit[gi+1])
            );
        end
    endgenerate

    assign tail_valid = chain_valid[MAX_ELEMS];
    assign tail_op    = chain_op[MAX_ELEMS];
    assign tail_value = chain_value[MAX_ELEMS];
    assign tail_hit   = chain_hit[MAX_ELEMS];

    always_comb
    begin
        full.a = (a_cnt_reg == FULL_CNT);
        full.u = (u_cnt_reg == FULL_CNT);
        full.n = (n_cnt_reg == FULL_CNT);
        need.u = tail_valid && !tail_hit.u;
        need.a = 1'b0;
        need.n = 1'b0;
        case (tail_op)
            suid_pkg::OP_LIST_A:
            begin
                need.a = tail_valid && !tail_hit.a;
            end
            suid_pkg::OP_LIST_B:
            begin
                // intersection only takes values already seen in the a store
                need.n = tail_valid && tail_hit.a && !tail_hit.n;
            end
            default:
            begin
                need.a = 1'b0;
                need.n = 1'b0;
            end
        endcase
        wr_en.a = need.a && !full.a;
        wr_en.u = need.u && !full.u;
        wr_en.n = need.n && !full.n;
        ovf = (need.a && full.a) || (need.u && full.u) || (need.n && full.n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            a_cnt_reg     <= '0;
            u_cnt_reg     <= '0;
            n_cnt_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tail_valid)
            begin
                busy_reg <= 1'b0;
            end
            if (wr_en.a)
            begin
                a_cnt_reg <= a_cnt_reg + CNT_W'(1);
            end
            if (wr_en.u)
            begin
                u_cnt_reg <= u_cnt_reg + CNT_W'(1);
            end
            if (wr_en.n)
            begin
                n_cnt_reg <= n_cnt_reg + CNT_W'(1);
            end
            res_valid_reg <= tail_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_valid)
        begin
            res_value_reg <= tail_value;
            res_u_add_reg <= wr_en.u;
            res_n_add_reg <= wr_en.n;
            res_ovf_reg   <= ovf;
        end
    end

    assign echo_ext  = {16'b0, res_value_reg};
    assign u_cnt_ext = {7'b0, u_cnt_reg};
    assign n_cnt_ext = {7'b0, n_cnt_reg};

    assign busy         = busy_reg;
    assign result_valid = res_valid_reg;
    assign echo_value   = echo_ext[15:0];
    assign union_added  = res_u_add_reg;
    assign inter_added  = res_n_add_reg;
    assign union_count  = u_cnt_ext[6:0];
    assign inter_count  = n_cnt_ext[6:0];
    assign overflow     = res_ovf_reg;

endmodule

// ===== dv/set_union_intersection_dedup_top_test.sv =====
`timescale 1ns / 100ps

module set_union_intersection_dedup_top_test;

    localparam int MAX_ELEMS   = 64;
    localparam int VALUE_BITS  = 16;
    localparam int POOL_SIZE   = 100;
    localparam int POOL_ITEMS  = 960;
    localparam int FRESH_PAIRS = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        STORE_A,
        STORE_UNION,
        STORE_INTER
    } store_sel_t;

    typedef struct {
        logic        op;
        logic [15:0] value;
        int          idle_pct;
    } list_element_t;

    typedef struct packed {
        logic [15:0] echo_value;
        logic        union_added;
        logic        inter_added;
        logic [6:0]  union_count;
        logic [6:0]  inter_count;
        logic        overflow;
    } set_update_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = suid_pkg::OP_LIST_A;
    logic [15:0] item_value = '0;
    logic        result_valid;
    logic [15:0] echo_value;
    logic        union_added;
    logic        inter_added;
    logic [6:0]  union_count;
    logic [6:0]  inter_count;
    logic        overflow;

    list_element_t elements_to_send [$];
    set_update_t   set_updates_due [$];
    list_element_t cur_element;
    bit            holding = 1'b0;
    int            error_count = 0;
    int            cycle_count = 0;

    // shadow copy of the three deduplicated stores
    logic [15:0] store_vals [3][MAX_ELEMS];
    int          store_len [3] = '{0, 0, 0};

    set_union_intersection_dedup_top #(
        .MAX_ELEMS  (MAX_ELEMS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .item_value   (item_value),
        .result_valid (result_valid),
        .echo_value   (echo_value),
        .union_added  (union_added),
        .inter_added  (inter_added),
        .union_count  (union_count),
        .inter_count  (inter_count),
        .overflow     (overflow)
    );

    function automatic bit store_holds(store_sel_t s, logic [15:0] v);
        for (int i = 0; i < store_len[s]; i++)
        begin
            if (store_vals[s][i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit store_append(store_sel_t s, logic [15:0] v, inout bit dropped);
        if (store_holds(s, v))
            return 1'b0;
        if (store_len[s] >= MAX_ELEMS)
        begin
            dropped = 1'b1;
            return 1'b0;
        end
        store_vals[s][store_len[s]] = v;
        store_len[s]++;
        return 1'b1;
    endfunction

    function automatic set_update_t merge_element(logic op, logic [15:0] v);
        set_update_t r;
        bit          dropped;
        dropped = 1'b0;
        r = '0;
        r.echo_value = v;
        if (op == suid_pkg::OP_LIST_A)
        begin
            void'(store_append(STORE_A, v, dropped));
            r.union_added = store_append(STORE_UNION, v, dropped);
        end
        else
        begin
            // membership only counts against a values already stored
            if (store_holds(STORE_A, v))
                r.inter_added = store_append(STORE_INTER, v, dropped);
            r.union_added = store_append(STORE_UNION, v, dropped);
        end
        r.union_count = 7'(store_len[STORE_UNION]);
        r.inter_count = 7'(store_len[STORE_INTER]);
        r.overflow    = dropped;
        return r;
    endfunction

    task automatic push_element(logic op, logic [15:0] v, int idle_pct);
        list_element_t e;
        e.op       = op;
        e.value    = v;
        e.idle_pct = idle_pct;
        elements_to_send.push_back(e);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: one request held until busy is low at an edge with start high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            opcode     <= suid_pkg::OP_LIST_A;
            item_value <= '0;
            holding = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                set_updates_due.push_back(merge_element(opcode, item_value));
                holding = 1'b0;
            end
            if (!holding && elements_to_send.size() > 0)
            begin
                cur_element = elements_to_send.pop_front();
                holding = 1'b1;
            end
            if (holding && $urandom_range(99) >= cur_element.idle_pct)
            begin
                start      <= 1'b1;
                opcode     <= cur_element.op;
                item_value <= cur_element.value;
            end
            else
            begin
                // garbage on the payload while start is low
                start      <= 1'b0;
                opcode     <= 1'($urandom_range(1));
                item_value <= 16'($urandom_range(16'hFFFF));
            end
        end
    end

    always @(posedge clk)
    begin
        set_update_t want;
        if (rst_n && result_valid)
        begin
            if (set_updates_due.size() == 0)
            begin
                $error("result strobe with no request outstanding, echo_value %0h", echo_value);
                error_count++;
            end
            else
            begin
                want = set_updates_due.pop_front();
                if (echo_value !== want.echo_value)
                begin
                    $error("echo_value: expected %0h, got %0h", want.echo_value, echo_value);
                    error_count++;
                end
                if (union_added !== want.union_added)
                begin
                    $error("union_added: expected %0d, got %0d", want.union_added, union_added);
                    error_count++;
                end
                if (inter_added !== want.inter_added)
                begin
                    $error("inter_added: expected %0d, got %0d", want.inter_added, inter_added);
                    error_count++;
                end
                if (union_count !== want.union_count)
                begin
                    $error("union_count: expected %0d, got %0d", want.union_count, union_count);
                    error_count++;
                end
                if (inter_count !== want.inter_count)
                begin
                    $error("inter_count: expected %0d, got %0d", want.inter_count, inter_count);
                    error_count++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0d, got %0d", want.overflow, overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] pool [$];
        logic [15:0] v;
        bit          seen;
        int          win;
        int          phase;
        int          idle;

        // directed: extremes, repeats, b before a, b after a
        push_element(suid_pkg::OP_LIST_A, 16'h0000, 0);
        push_element(suid_pkg::OP_LIST_A, 16'hFFFF, 0);
        push_element(suid_pkg::OP_LIST_A, 16'h0000, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h0000, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h0000, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h1234, 0);
        push_element(suid_pkg::OP_LIST_A, 16'h1234, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h1234, 0);
        push_element(suid_pkg::OP_LIST_B, 16'hFFFF, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h5555, 0);
        push_element(suid_pkg::OP_LIST_A, 16'hAAAA, 0);
        push_element(suid_pkg::OP_LIST_B, 16'hAAAA, 0);
        push_element(suid_pkg::OP_LIST_A, 16'h5555, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h5555, 0);
        push_element(suid_pkg::OP_LIST_A, 16'h8000, 0);
        push_element(suid_pkg::OP_LIST_B, 16'h7FFF, 0);
        push_element(suid_pkg::OP_LIST_A, 16'h7FFF, 0);
        push_element(suid_pkg::OP_LIST_A, 16'h8000, 0);

        while (pool.size() < POOL_SIZE)
        begin
            v = 16'($urandom_range(16'hFFFF));
            seen = 1'b0;
            foreach (pool[k])
            begin
                if (pool[k] == v)
                    seen = 1'b1;
            end
            if (!seen)
                pool.push_back(v);
        end

        // a slowly widening window so stores fill gradually and then overflow
        for (int i = 0; i < POOL_ITEMS + 2 * FRESH_PAIRS; i++)
        begin
            phase = i * 4 / (POOL_ITEMS + 2 * FRESH_PAIRS);
            idle = (phase == 1) ? 68 : (phase == 3) ? 10 : 0;
            if (i < POOL_ITEMS)
            begin
                win = (6 + i / 8 < POOL_SIZE - 1) ? 6 + i / 8 : POOL_SIZE - 1;
                if ($urandom_range(99) < 3)
                    v = 16'($urandom_range(16'hFFFF));
                else
                    v = pool[$urandom_range(win)];
                push_element(1'($urandom_range(1)), v, idle);
            end
            else if (i % 2 == 0)
            begin
                // new value for a full a store, then the same value from list b
                v = 16'($urandom_range(16'hFFFF));
                push_element(suid_pkg::OP_LIST_A, v, idle);
                push_element(suid_pkg::OP_LIST_B, v, idle);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (elements_to_send.size() > 0 || holding || set_updates_due.size() > 0)
            @(posedge clk);
        repeat (MAX_ELEMS + 8) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
